/* hw/rtl/patch_flow_densifier_defines.svh */
// ----------------------------------------------------------------------------
// Patch flow densifier assertion macros
// Shared property wrappers for the densifier's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PATCH_FLOW_DENSIFIER_DEFINES_SVH
`define PATCH_FLOW_DENSIFIER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define PFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define PFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// Patch flow densifier package
// Constants, payload types, store entry layout and controller interface types.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // Built image and patch limits.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_PATCH   = 32;
  localparam int COVER_CAP   = 1024;

  // Store geometry: one entry per pixel, row-major.
  localparam int X_W         = $clog2(MAX_WIDTH);
  localparam int Y_W         = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = X_W + Y_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // Field widths.
  localparam int FLOW_W      = 16;
  localparam int SUM_W       = 26;
  localparam int CNT_W       = 11;
  localparam int DIM_W       = 9;
  localparam int PS_W        = 6;
  localparam int HALF_W      = PS_W - 1;
  localparam int WALK_W      = PS_W - 1;
  localparam int COORD_W     = DIM_W + 1;

  // Divider: one quotient bit per cycle over the whole sum magnitude.
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_SIDE   = 2'd2;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [PS_W-1:0]  RST_PATCH_SIDE   = 6'd8;

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Input request payload.
  typedef struct packed {
    logic                     operation;
    logic [7:0]               patch_x;
    logic [7:0]               patch_y;
    logic                     patch_valid;
    logic signed [FLOW_W-1:0] flow_u;
    logic signed [FLOW_W-1:0] flow_v;
    logic [7:0]               pixel_x;
    logic [7:0]               pixel_y;
  } pfd_in_t;

  // Result request payload.
  typedef struct packed {
    logic signed [FLOW_W-1:0] dense_u;
    logic signed [FLOW_W-1:0] dense_v;
    logic                     covered;
  } pfd_out_t;

  // One store entry.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_u;
    logic signed [SUM_W-1:0] sum_v;
    logic [CNT_W-1:0]        count;
  } pfd_entry_t;

  localparam int ENTRY_W = $bits(pfd_entry_t);

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_DIVIDE,
    ST_RESULT
  } pfd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear_step;
    logic walk_step;
    logic rd_issue;
    logic rd_finish;
    logic out_load;
  } pfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_op;
    logic in_add_go;
    logic clear_last;
    logic walk_last;
    logic rd_covered;
    logic div_done;
    logic out_free;
  } pfd_stat_t;

endpackage

/* hw/rtl/pfd_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pfd_div.sv */
// ----------------------------------------------------------------------------
// Patch flow densifier divider
// Signed sum over unsigned count, truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module pfd_div import pfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  numer,
  input  logic [CNT_W-1:0]         denom,
  output logic                     done,
  output logic signed [FLOW_W-1:0] quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic [SUM_W-1:0]     mag_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     den_r;
  logic                 neg_r;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 fits;
  logic [SUM_W-1:0]     quot_full;

  // Restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_r, mag_r[SUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DIV_CNT_W'(1);
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers; the quotient builds up in place of the magnitude.
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= numer[SUM_W-1] ? SUM_W'(-numer) : SUM_W'(numer);
      rem_r <= '0;
      den_r <= denom;
      neg_r <= numer[SUM_W-1];
    end else if (busy_r) begin
      mag_r <= {mag_r[SUM_W-2:0], fits};
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // Restore the sign and keep the low flow bits.
  assign quot_full = neg_r ? (~mag_r + SUM_W'(1)) : mag_r;
  assign quot      = quot_full[FLOW_W-1:0];
  assign done      = done_r;

endmodule

/* hw/rtl/pfd_dpath.sv */
// ----------------------------------------------------------------------------
// Patch flow densifier datapath
// Configuration, window walker, store read-modify-write, dividers and output.
// ----------------------------------------------------------------------------
module pfd_dpath import pfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  pfd_in_t              in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output pfd_out_t             out_data,
  input  pfd_cmd_t             cmd,
  output pfd_stat_t            stat
);

  logic [DIM_W-1:0]   img_w_r;
  logic [DIM_W-1:0]   img_h_r;
  logic [PS_W-1:0]    psize_r;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [PS_W-1:0]    ps_eff;
  logic [HALF_W-1:0]  half;
  logic [PS_W-1:0]    side_m1;
  pfd_in_t            item_r;
  logic [WALK_W-1:0]  wx_r;
  logic [WALK_W-1:0]  wy_r;
  logic [COORD_W-1:0] xt;
  logic [COORD_W-1:0] yt;
  logic               in_win;
  logic [ADDR_W-1:0]  walk_addr;
  logic [ADDR_W-1:0]  pix_addr;
  logic               pix_in_range;
  logic               wr_pend_r;
  logic [ADDR_W-1:0]  wr_addr_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  pfd_entry_t         ram_wentry;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  pfd_entry_t         rd_entry;
  logic               rd_covered;
  logic               covered_r;
  logic               div_start;
  logic               done_u;
  logic               done_v;
  logic [FLOW_W-1:0]  quot_u;
  logic [FLOW_W-1:0]  quot_v;
  logic               out_valid_r;
  pfd_out_t           out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      psize_r <= RST_PATCH_SIDE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata;
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata;
        CFG_PATCH_SIDE:   psize_r <= cfg_wdata[PS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration to the built limits.
  assign w_eff   = (img_w_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : img_w_r;
  assign h_eff   = (img_h_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : img_h_r;
  assign ps_eff  = (psize_r > PS_W'(MAX_PATCH)) ? PS_W'(MAX_PATCH) : psize_r;
  assign half    = ps_eff[PS_W-1:1];
  assign side_m1 = {half, 1'b0} - PS_W'(1);

  // Accepted request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Window walker, row by row over the full square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r <= '0;
      wy_r <= '0;
    end else if (cmd.load) begin
      wx_r <= '0;
      wy_r <= '0;
    end else if (cmd.walk_step) begin
      if (wx_r == side_m1[WALK_W-1:0]) begin
        wx_r <= '0;
        wy_r <= wy_r + WALK_W'(1);
      end else begin
        wx_r <= wx_r + WALK_W'(1);
      end
    end
  end

  // Target pixel of the walker; negative coordinates show up in the top bit.
  assign xt = COORD_W'(item_r.patch_x) - COORD_W'(half) + COORD_W'(wx_r);
  assign yt = COORD_W'(item_r.patch_y) - COORD_W'(half) + COORD_W'(wy_r);
  assign in_win = !xt[COORD_W-1] && (xt[COORD_W-2:0] < w_eff) &&
                  !yt[COORD_W-1] && (yt[COORD_W-2:0] < h_eff);
  assign walk_addr = {yt[Y_W-1:0], xt[X_W-1:0]};

  // Pixel addressed by a read request.
  assign pix_addr     = {item_r.pixel_y, item_r.pixel_x};
  assign pix_in_range = (DIM_W'(item_r.pixel_x) < w_eff) &&
                        (DIM_W'(item_r.pixel_y) < h_eff);

  // Pending accumulate: read issued this cycle, written back the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.walk_step && in_win;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= walk_addr;
  end

  // Clearing pass counter after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  assign rd_entry = pfd_entry_t'(ram_rdata);

  // Store read port.
  assign ram_re    = (cmd.walk_step && in_win) || cmd.rd_issue;
  assign ram_raddr = cmd.rd_issue ? pix_addr : walk_addr;

  // Store write port: clearing, read-and-clear, or accumulate.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = wr_addr_r;
    ram_wentry = '0;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
    end else if (cmd.rd_finish) begin
      ram_we    = pix_in_range;
      ram_waddr = pix_addr;
    end else if (wr_pend_r && (rd_entry.count < CNT_W'(COVER_CAP))) begin
      ram_we           = 1'b1;
      ram_wentry.sum_u = rd_entry.sum_u +
                         {{(SUM_W-FLOW_W){item_r.flow_u[FLOW_W-1]}}, item_r.flow_u};
      ram_wentry.sum_v = rd_entry.sum_v +
                         {{(SUM_W-FLOW_W){item_r.flow_v[FLOW_W-1]}}, item_r.flow_v};
      ram_wentry.count = rd_entry.count + CNT_W'(1);
    end
  end

  pfd_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(ram_wentry)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Averaging starts only for a covered pixel inside the image.
  assign rd_covered = pix_in_range && (rd_entry.count != '0);
  assign div_start  = cmd.rd_finish && rd_covered;

  always_ff @(posedge clk) begin
    if (cmd.rd_finish) begin
      covered_r <= rd_covered;
    end
  end

  pfd_div u_div_u (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (rd_entry.sum_u),
    .denom (rd_entry.count),
    .done  (done_u),
    .quot  (quot_u)
  );

  pfd_div u_div_v (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (rd_entry.sum_v),
    .denom (rd_entry.count),
    .done  (done_v),
    .quot  (quot_v)
  );

  // Output register; a waiting result is held until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (covered_r) begin
        out_data_r.dense_u <= quot_u;
        out_data_r.dense_v <= quot_v;
        out_data_r.covered <= 1'b1;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller.
  assign stat.in_op      = in_data.operation;
  assign stat.in_add_go  = in_data.patch_valid && (half != '0);
  assign stat.clear_last = &clr_cnt_r;
  assign stat.walk_last  = (wx_r == side_m1[WALK_W-1:0]) &&
                           (wy_r == side_m1[WALK_W-1:0]);
  assign stat.rd_covered = rd_covered;
  assign stat.div_done   = done_u && done_v;
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

/* hw/rtl/pfd_ctrl.sv */
// ----------------------------------------------------------------------------
// Patch flow densifier controller
// Sequences the clearing pass, patch walks and pixel reads.
// ----------------------------------------------------------------------------
`include "patch_flow_densifier_defines.svh"

module pfd_ctrl import pfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output pfd_cmd_t  cmd,
  input  pfd_stat_t stat
);

  pfd_state_t state_r;
  pfd_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.in_op == OP_READ) begin
            state_nxt = ST_RD_ISSUE;
          end else if (stat.in_add_go) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (stat.walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:    state_nxt = ST_IDLE;
      ST_RD_ISSUE: state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: begin
        state_nxt = stat.rd_covered ? ST_DIVIDE : ST_RESULT;
      end
      ST_DIVIDE: begin
        if (stat.div_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs per state.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR:    cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_WALK:     cmd.walk_step = 1'b1;
      ST_DRAIN:    ;
      ST_RD_ISSUE: cmd.rd_issue = 1'b1;
      ST_RD_WAIT:  cmd.rd_finish = 1'b1;
      ST_DIVIDE:   ;
      ST_RESULT:   cmd.out_load = stat.out_free;
      default:     ;
    endcase
  end

  // A result is loaded only into a free output register.
  `PFD_ASSERT_SAME(a_load_free, cmd.out_load, stat.out_free, "result loaded over a held result")
  // Loading a result ends the read request.
  `PFD_ASSERT_NEXT(a_load_idle, cmd.out_load, state_r == ST_IDLE, "no return to idle after result")
  // The dividers finish only while the controller waits for them.
  `PFD_ASSERT_SAME(a_done_divide, stat.div_done, state_r == ST_DIVIDE, "divider done out of place")

endmodule

/* hw/rtl/patch_flow_densifier.sv */
// Add request: accepted in idle, then a walk over the even-sided window square, then a drain step.
// Read request: issue, store read, the 26-step divider when covered (skipped otherwise), then the result.
// One request at a time; the store's single read and write ports set the walk rate.
// A waiting result is held in the output register while the next request is taken.
// After reset a clearing pass zeroes every store entry; in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
// Patch flow densifier
// Splats patch flow vectors into a per-pixel store and returns pixel averages.
// ----------------------------------------------------------------------------
module patch_flow_densifier import pfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pfd_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pfd_out_t             out_data
);

  pfd_cmd_t  cmd;
  pfd_stat_t stat;

  // Sequencer.
  pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Store, arithmetic and output register.
  pfd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
